// ===== design/dmm_pkg.sv =====
package dmm_pkg;

  localparam int unsigned DigitW = 4;
  localparam int unsigned CarryW = 5;  // carry never exceeds 26
  localparam int unsigned SumW   = 9;  // digit + 15*15 + carry stays below 512

  typedef logic [DigitW-1:0] digit_t;
  typedef logic [CarryW-1:0] carry_t;
  typedef logic [SumW-1:0]   sum_t;

  // per-cell control, driven by the sequencer in the top level
  typedef struct packed {
    logic load;   // capture the incoming operand digit pair
    logic mult;   // add multiplier digit * b, shift a down and b up
    logic step;   // fold the carry-save sum into a digit and a carry
    logic shift;  // move product digits one cell toward the output
  } cell_ctrl_t;

  typedef struct packed {
    carry_t q;
    digit_t r;
  } div10_t;

  // split a small sum into quotient and remainder by ten
  // (reciprocal multiply, exact for sums below 320)
  function automatic div10_t split10(sum_t s);
    logic [16:0] m;
    sum_t        rem;
    div10_t      res;
    m     = 17'(s) * 17'd205;
    res.q = m[15:11];
    rem   = s - (SumW'(res.q) * SumW'(10));
    res.r = rem[DigitW-1:0];
    return res;
  endfunction

endpackage

// ===== design/dmm_cell.sv =====
module dmm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dmm_pkg::cell_ctrl_t ctrl_i,
  input  dmm_pkg::digit_t     load_a_i,
  input  dmm_pkg::digit_t     load_b_i,
  input  dmm_pkg::digit_t     mult_digit_i,
  input  dmm_pkg::digit_t     a_up_i,
  input  dmm_pkg::digit_t     b_dn_i,
  input  dmm_pkg::digit_t     p_up_i,
  input  dmm_pkg::carry_t     carry_i,
  output dmm_pkg::digit_t     a_o,
  output dmm_pkg::digit_t     b_o,
  output dmm_pkg::digit_t     p_o,
  output dmm_pkg::carry_t     carry_o,
  output dmm_pkg::carry_t     carry_next_o
);

  dmm_pkg::digit_t a_q, a_d;
  dmm_pkg::digit_t b_q, b_d;
  dmm_pkg::digit_t p_q, p_d;
  dmm_pkg::carry_t c_q, c_d;

  logic [7:0]       prod;
  dmm_pkg::sum_t    sum;
  dmm_pkg::div10_t  split;

  // carry-save digit: value is p + 10 * c, carry goes to the upper neighbor
  assign prod  = ctrl_i.mult ? ({4'd0, mult_digit_i} * {4'd0, b_q}) : 8'd0;
  assign sum   = dmm_pkg::SumW'(p_q) + dmm_pkg::SumW'(prod) + dmm_pkg::SumW'(carry_i);
  assign split = dmm_pkg::split10(sum);

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    p_d = p_q;
    c_d = c_q;
    if (ctrl_i.load) begin
      a_d = load_a_i;
      b_d = load_b_i;
    end
    if (ctrl_i.mult) begin
      a_d = a_up_i;
      b_d = b_dn_i;
    end
    if (ctrl_i.step) begin
      p_d = split.r;
      c_d = split.q;
    end
    if (ctrl_i.shift) begin
      p_d = p_up_i;
      c_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
      p_q <= '0;
      c_q <= '0;
    end else begin
      a_q <= a_d;
      b_q <= b_d;
      p_q <= p_d;
      c_q <= c_d;
    end
  end

  assign a_o          = a_q;
  assign b_o          = b_q;
  assign p_o          = p_q;
  assign carry_o      = c_q;
  assign carry_next_o = ctrl_i.step ? split.q : '0;

endmodule

// ===== design/decimal_multidigit_multiplier_core.sv =====
// schoolbook decimal multiplier, DIGITS digits per operand
//
// input stream (s_axis): one request per operand digit pair, least
// significant first; tlast marks the final pair and starts the multiply.
// pairs beyond DIGITS are dropped, a nonzero one flags overflow.
// output stream (m_axis): DIGITS product digits, least significant first,
// tlast on the most significant one, tuser = overflow (same in every digit).
//
// timing: a non-final pair leaves s_axis_tready high. after a final pair the
// cell row spends the multiply state on partial products (one operand-a digit
// per cycle across all cells), then the flush state letting the carry-save
// carries settle, then hands out digits through the output register, one per
// cycle when the receiver keeps tready high. s_axis_tready comes back when
// the last digit sits in the output register.
// a stall on m_axis holds the output register; during emission it also
// freezes the cell row, while loading, multiply and settle run on regardless.
// reset (rst_ni low) clears all operand, product and carry cells, the load
// position and the overflow flag; stores are also left all zero after every
// emission.
module decimal_multidigit_multiplier_core #(
  parameter int unsigned DIGITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input requests
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [3:0] digit_a, [7:4] digit_b
  input  logic       s_axis_tlast,   // final_digit
  // product digits
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [3:0] product_digit, [7:4] zero
  output logic       m_axis_tlast,   // last_digit
  output logic       m_axis_tuser    // overflow
);

  localparam int unsigned CntW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int unsigned PosW = $clog2(DIGITS + 1);

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MULT  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [PosW-1:0]  load_pos_q, load_pos_d;
  logic             ovf_q, ovf_d;
  logic             dropped_q, dropped_d;   // a nonzero b digit left the top cell

  logic             out_valid_q, out_valid_d;
  dmm_pkg::digit_t  out_digit_q, out_digit_d;
  logic             out_last_q, out_last_d;
  logic             out_ovf_q, out_ovf_d;

  dmm_pkg::digit_t  in_a, in_b;
  logic             in_fire, out_take, cnt_last, pos_full;

  // cell row wiring
  dmm_pkg::cell_ctrl_t ctrl_w [DIGITS];
  dmm_pkg::digit_t     a_w    [DIGITS];
  dmm_pkg::digit_t     b_w    [DIGITS];
  dmm_pkg::digit_t     p_w    [DIGITS];
  dmm_pkg::carry_t     c_w    [DIGITS];
  dmm_pkg::carry_t     cn_w   [DIGITS];

  assign in_a     = s_axis_tdata[3:0];
  assign in_b     = s_axis_tdata[7:4];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_take = !out_valid_q || m_axis_tready;
  assign cnt_last = (cnt_q == CntW'(DIGITS - 1));
  assign pos_full = (load_pos_q == PosW'(DIGITS));

  for (genvar j = 0; j < DIGITS; j++) begin : g_cell
    dmm_pkg::digit_t a_up, b_dn, p_up;
    dmm_pkg::carry_t c_in;

    assign ctrl_w[j].load  = in_fire && (load_pos_q == PosW'(j));
    assign ctrl_w[j].mult  = (state_q == ST_MULT);
    assign ctrl_w[j].step  = (state_q == ST_MULT) || (state_q == ST_FLUSH);
    assign ctrl_w[j].shift = (state_q == ST_EMIT) && out_take;

    // a and the product move toward cell 0, b and carries move up
    if (j == DIGITS - 1) begin : g_top
      assign a_up = '0;
      assign p_up = '0;
    end else begin : g_mid
      assign a_up = a_w[j+1];
      assign p_up = p_w[j+1];
    end
    if (j == 0) begin : g_bot
      assign b_dn = '0;
      assign c_in = '0;
    end else begin : g_up
      assign b_dn = b_w[j-1];
      assign c_in = c_w[j-1];
    end

    dmm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_w[j]),
      .load_a_i     (in_a),
      .load_b_i     (in_b),
      .mult_digit_i (a_w[0]),
      .a_up_i       (a_up),
      .b_dn_i       (b_dn),
      .p_up_i       (p_up),
      .carry_i      (c_in),
      .a_o          (a_w[j]),
      .b_o          (b_w[j]),
      .p_o          (p_w[j]),
      .carry_o      (c_w[j]),
      .carry_next_o (cn_w[j])
    );
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    load_pos_d  = load_pos_q;
    ovf_d       = ovf_q;
    dropped_d   = dropped_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_digit_d = out_digit_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;

    // a carry out of the top cell means the product needs more digits
    if (cn_w[DIGITS-1] != '0) begin
      ovf_d = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (pos_full) begin
            if ((in_a != '0) || (in_b != '0)) begin
              ovf_d = 1'b1;
            end
          end else begin
            load_pos_d = load_pos_q + 1'b1;
          end
          if (s_axis_tlast) begin
            state_d    = ST_MULT;
            cnt_d      = '0;
            dropped_d  = 1'b0;
            load_pos_d = '0;
          end
        end
      end
      ST_MULT: begin
        // partial products that land at position DIGITS or above
        if ((a_w[0] != '0) && dropped_q) begin
          ovf_d = 1'b1;
        end
        dropped_d = dropped_q || (b_w[DIGITS-1] != '0);
        cnt_d     = cnt_q + 1'b1;
        if (cnt_last) begin
          state_d = ST_FLUSH;
          cnt_d   = '0;
        end
      end
      ST_FLUSH: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_last) begin
          state_d = ST_EMIT;
          cnt_d   = '0;
        end
      end
      ST_EMIT: begin
        if (out_take) begin
          out_valid_d = 1'b1;
          out_digit_d = p_w[0];
          out_last_d  = cnt_last;
          out_ovf_d   = ovf_q;
          cnt_d       = cnt_q + 1'b1;
          if (cnt_last) begin
            state_d = ST_IDLE;
            cnt_d   = '0;
            ovf_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      load_pos_q  <= '0;
      ovf_q       <= 1'b0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      load_pos_q  <= load_pos_d;
      ovf_q       <= ovf_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_digit_q <= out_digit_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_digit_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_ovf_q;

endmodule

// ===== design/dmm_checker.sv =====
module dmm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  // a stalled product digit holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("product digit changed while stalled");

  // every emitted digit is decimal
  a_out_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:4] == 4'd0) && (m_axis_tdata[3:0] <= 4'd9))
    else $error("product digit out of range");

  // a final pair starts the multiply, no new request taken next cycle
  a_busy_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken right after final pair");

  // no loading while an emission is still in progress
  a_no_load_mid_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready in the middle of an emission");

endmodule

bind decimal_multidigit_multiplier_core dmm_checker u_dmm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
